// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the UTF-8 validator.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/utf8v_pkg.sv =====
// Package of the UTF-8 validator: status and command codes, register indexes,
// code point constants and the overlong floor lookup. No dependencies.
`default_nettype none

package utf8v_pkg;

	localparam int CHAR_W    = 10;
	localparam int BYTE_W    = 12;
	localparam int CP_W      = 21;
	localparam int CFG_DATA_W = 12;

	localparam logic [CHAR_W-1:0] CHAR_LIMIT_RST = 10'd500;
	localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = 12'd2000;

	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

	typedef enum logic [2:0] {
		ST_PROGRESS  = 3'd0,
		ST_VALID     = 3'd1,
		ST_INVALID   = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_END  = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_CHAR_LIMIT = 1'b0,
		CFG_BYTE_LIMIT = 1'b1
	} cfg_reg_t;

	// Smallest code point allowed for a sequence of the given length class.
	function automatic logic [CP_W-1:0] class_floor(input logic [1:0] cls);
		logic [CP_W-1:0] f;
		unique case (cls)
			2'd0: f = 21'h000000;
			2'd1: f = 21'h000080;
			2'd2: f = 21'h000800;
			2'd3: f = 21'h010000;
			default: f = 21'h000000;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== src/utf8v_if.sv =====
// Channel interfaces of the UTF-8 validator: text byte input and result output.
// Depends on utf8v_pkg.
`default_nettype none

interface utf8v_in_if;
	import utf8v_pkg::*;

	logic       valid;
	logic       ready;
	cmd_t       command;
	logic [7:0] text_byte;

	modport source (output valid, output command, output text_byte, input ready);
	modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface utf8v_out_if;
	import utf8v_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic              final_verdict;
	logic              char_complete;
	logic [CP_W-1:0]   code_point;
	logic [CHAR_W-1:0] chars_seen;
	logic [BYTE_W-1:0] bytes_seen;

	modport source (output valid, output status, output final_verdict, output char_complete,
		output code_point, output chars_seen, output bytes_seen, input ready);
	modport sink   (input valid, input status, input final_verdict, input char_complete,
		input code_point, input chars_seen, input bytes_seen, output ready);
endinterface

`default_nettype wire

// ===== src/utf8_validate_count_top.sv =====
// Streaming UTF-8 validator with character and byte limits, top level.
// Depends on utf8v_pkg, utf8v_if.sv and assert_macros.svh.
//
//   channel    | dir | content
//   text_in    | in  | command, text_byte
//   result_out | out | status, final_verdict, char_complete, code_point,
//              |     | chars_seen, bytes_seen
//   cfg_*      | in  | char_limit / byte_limit writes, no read-back
//
// One transaction per cycle unless the result stalls; input register, then result register.
// Decode, validation and counter update sit combinationally between the two registers.
// A stalled result holds the output register; the input register takes one more byte only if empty.
// Reset clears decoder state and counters and loads the limits with 500 and 2000.
`default_nettype none

module utf8_validate_count_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire utf8v_pkg::cfg_reg_t       cfg_index,
	input  wire [utf8v_pkg::CFG_DATA_W-1:0] cfg_data,
	utf8v_in_if.sink                       text_in,
	utf8v_out_if.source                    result_out
);
	import utf8v_pkg::*;

	// Limits
	logic [CHAR_W-1:0] char_limit_q;
	logic [BYTE_W-1:0] byte_limit_q;

	// Input register
	logic       valid_s1;
	cmd_t       command_s1;
	logic [7:0] text_byte_s1;

	// Decoder state
	logic [1:0]        bytes_pending_q;
	logic [CP_W-1:0]   partial_point_q;
	logic [1:0]        overlong_floor_q;
	logic [CHAR_W-1:0] char_total_q;
	logic [BYTE_W-1:0] byte_total_q;
	status_t           first_error_q;

	// Result register
	logic              valid_s2;
	status_t           status_s2;
	logic              final_verdict_s2;
	logic              char_complete_s2;
	logic [CP_W-1:0]   code_point_s2;
	logic [CHAR_W-1:0] chars_seen_s2;
	logic [BYTE_W-1:0] bytes_seen_s2;

	// Next values
	logic [1:0]        pend_d;
	logic [CP_W-1:0]   part_d;
	logic [1:0]        floor_d;
	logic [CHAR_W-1:0] ct_d;
	logic [BYTE_W-1:0] bt_d;
	status_t           fe_d;
	status_t           status_d;
	logic              done_d;
	logic [CP_W-1:0]   cp_d;
	logic [CHAR_W-1:0] chars_out_d;
	logic [BYTE_W-1:0] bytes_out_d;

	logic [BYTE_W:0]   byte_next;
	logic [CHAR_W:0]   char_next;
	logic [CP_W-1:0]   cont_cp;
	logic              fin_req;
	logic [CP_W-1:0]   fin_cp;
	logic [1:0]        fin_cls;

	logic adv;

	assign adv            = valid_s1 && (!valid_s2 || result_out.ready);
	assign text_in.ready  = !valid_s1 || adv;

	assign byte_next = {1'b0, byte_total_q} + {{BYTE_W{1'b0}}, 1'b1};
	assign char_next = {1'b0, char_total_q} + {{CHAR_W{1'b0}}, 1'b1};
	assign cont_cp   = {partial_point_q[CP_W-7:0], text_byte_s1[5:0]};

	always_comb begin
		pend_d      = bytes_pending_q;
		part_d      = partial_point_q;
		floor_d     = overlong_floor_q;
		ct_d        = char_total_q;
		bt_d        = byte_total_q;
		fe_d        = first_error_q;
		status_d    = first_error_q;
		done_d      = 1'b0;
		cp_d        = '0;
		chars_out_d = char_total_q;
		bytes_out_d = byte_total_q;
		fin_req     = 1'b0;
		fin_cp      = '0;
		fin_cls     = 2'd0;

		if (command_s1 == CMD_END) begin
			if (first_error_q == ST_TOO_LONG || byte_total_q > byte_limit_q) begin
				status_d = ST_TOO_LONG;
			end else if (first_error_q != ST_PROGRESS) begin
				status_d = first_error_q;
			end else if (bytes_pending_q != 2'd0) begin
				status_d = ST_TRUNCATED;
			end else begin
				status_d = ST_VALID;
			end
			pend_d  = 2'd0;
			part_d  = '0;
			floor_d = 2'd0;
			ct_d    = '0;
			bt_d    = '0;
			fe_d    = ST_PROGRESS;
		end else begin
			// byte overflow overrides any earlier error
			if (byte_next > {1'b0, byte_limit_q}) begin
				fe_d = ST_TOO_LONG;
			end
			bt_d = byte_next[BYTE_W] ? '1 : byte_next[BYTE_W-1:0];

			if (text_byte_s1[7:6] == 2'b10 && bytes_pending_q != 2'd0) begin
				pend_d = bytes_pending_q - 2'd1;
				if (bytes_pending_q == 2'd1) begin
					fin_req = 1'b1;
					fin_cp  = cont_cp;
					fin_cls = overlong_floor_q;
					part_d  = '0;
					floor_d = 2'd0;
				end else begin
					part_d = cont_cp;
				end
			end else begin
				if (bytes_pending_q != 2'd0) begin
					if (fe_d == ST_PROGRESS) fe_d = ST_INVALID;
					pend_d  = 2'd0;
					part_d  = '0;
					floor_d = 2'd0;
				end
				priority casez (text_byte_s1)
					8'b0???????: begin
						fin_req = 1'b1;
						fin_cp  = {{(CP_W-8){1'b0}}, text_byte_s1};
						fin_cls = 2'd0;
					end
					8'b110?????: begin
						part_d  = {{(CP_W-5){1'b0}}, text_byte_s1[4:0]};
						pend_d  = 2'd1;
						floor_d = 2'd1;
					end
					8'b1110????: begin
						part_d  = {{(CP_W-4){1'b0}}, text_byte_s1[3:0]};
						pend_d  = 2'd2;
						floor_d = 2'd2;
					end
					8'b11110???: begin
						part_d  = {{(CP_W-3){1'b0}}, text_byte_s1[2:0]};
						pend_d  = 2'd3;
						floor_d = 2'd3;
					end
					default: begin
						if (fe_d == ST_PROGRESS) fe_d = ST_INVALID;
					end
				endcase
			end

			if (fin_req) begin
				if (fin_cp < class_floor(fin_cls) || fin_cp > CP_MAX ||
						(fin_cp >= SURR_LO && fin_cp <= SURR_HI)) begin
					if (fe_d == ST_PROGRESS) fe_d = ST_INVALID;
				end else begin
					done_d = 1'b1;
					cp_d   = fin_cp;
					if (char_next > {1'b0, char_limit_q} && fe_d == ST_PROGRESS) begin
						fe_d = ST_TOO_LONG;
					end
					ct_d = char_next[CHAR_W] ? '1 : char_next[CHAR_W-1:0];
				end
			end

			status_d    = fe_d;
			chars_out_d = ct_d;
			bytes_out_d = bt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_limit_q <= CHAR_LIMIT_RST;
			byte_limit_q <= BYTE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHAR_LIMIT: char_limit_q <= cfg_data[CHAR_W-1:0];
				CFG_BYTE_LIMIT: byte_limit_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			command_s1   <= text_in.command;
			text_byte_s1 <= text_in.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_pending_q  <= 2'd0;
			partial_point_q  <= '0;
			overlong_floor_q <= 2'd0;
			char_total_q     <= '0;
			byte_total_q     <= '0;
			first_error_q    <= ST_PROGRESS;
		end else if (adv) begin
			bytes_pending_q  <= pend_d;
			partial_point_q  <= part_d;
			overlong_floor_q <= floor_d;
			char_total_q     <= ct_d;
			byte_total_q     <= bt_d;
			first_error_q    <= fe_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2        <= status_d;
			final_verdict_s2 <= (command_s1 == CMD_END);
			char_complete_s2 <= done_d;
			code_point_s2    <= cp_d;
			chars_seen_s2    <= chars_out_d;
			bytes_seen_s2    <= bytes_out_d;
		end
	end

	assign result_out.valid         = valid_s2;
	assign result_out.status        = status_s2;
	assign result_out.final_verdict = final_verdict_s2;
	assign result_out.char_complete = char_complete_s2;
	assign result_out.code_point    = code_point_s2;
	assign result_out.chars_seen    = chars_seen_s2;
	assign result_out.bytes_seen    = bytes_seen_s2;

`include "assert_macros.svh"

	`ASSERT_IMPL(a_floor_idle, bytes_pending_q == 2'd0, overlong_floor_q == 2'd0,
		"overlong class left set with no sequence pending")
	`ASSERT_NEXT(a_end_clears, adv && command_s1 == CMD_END,
		byte_total_q == '0 && bytes_pending_q == 2'd0 && first_error_q == ST_PROGRESS,
		"end of text did not clear the text state")
	`ASSERT_IMPL(a_end_no_char, valid_s2 && final_verdict_s2,
		!char_complete_s2 && code_point_s2 == '0 && status_s2 != ST_PROGRESS,
		"final verdict carries a character or no verdict")
	`ASSERT_IMPL(a_cp_legal, valid_s2 && char_complete_s2,
		code_point_s2 <= CP_MAX && (code_point_s2 < SURR_LO || code_point_s2 > SURR_HI),
		"completed character outside the legal code point range")

endmodule

`default_nettype wire

// ===== tb/utf8_validate_count_top_tb.sv =====
// Testbench of utf8_validate_count_top: directed texts, then random UTF-8 texts
// under several limit settings, checked against an in-bench decoder model.
// Depends on utf8v_pkg, utf8v_if.sv and the validator RTL.
`timescale 1ns / 1ps
`default_nettype none

module utf8_validate_count_top_tb;
	import utf8v_pkg::*;

	typedef struct packed {
		status_t           status;
		logic              final_verdict;
		logic              char_complete;
		logic [CP_W-1:0]   code_point;
		logic [CHAR_W-1:0] chars_seen;
		logic [BYTE_W-1:0] bytes_seen;
	} verdict_t;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
		bit         typed;
		verdict_t   want;
	} script_row_t;

	localparam verdict_t NO_VERDICT = '{ST_PROGRESS, 1'b0, 1'b0, 21'h0, 10'd0, 12'd0};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	utf8v_in_if  text_ch ();
	utf8v_out_if result_ch ();

	utf8_validate_count_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text_in    (text_ch),
		.result_out (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder model state
	logic [CHAR_W-1:0] lim_chars;
	logic [BYTE_W-1:0] lim_bytes;
	logic [1:0]        dec_pend;
	logic [CP_W-1:0]   dec_part;
	logic [1:0]        dec_cls;
	logic [CHAR_W-1:0] txt_chars;
	logic [BYTE_W-1:0] txt_bytes;
	status_t           txt_err;

	verdict_t   pending_verdicts[$];
	logic [7:0] text_bytes[$];
	int         n_fail = 0;
	int         n_sent = 0;
	int         src_idle = 0;
	int         rcv_idle = 0;

	script_row_t script [29] = '{
		'{CMD_BYTE, 8'h00, 1'b1, '{ST_PROGRESS, 1'b0, 1'b1, 21'h0, 10'd1, 12'd1}},
		'{CMD_BYTE, 8'h7F, 1'b1, '{ST_PROGRESS, 1'b0, 1'b1, 21'h7F, 10'd2, 12'd2}},
		'{CMD_BYTE, 8'hC2, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h80, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hEF, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hBF, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hBF, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hF4, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h8F, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hBF, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hBF, 1'b0, NO_VERDICT},
		'{CMD_END,  8'hA5, 1'b1, '{ST_VALID, 1'b1, 1'b0, 21'h0, 10'd5, 12'd11}},
		// overlong, surrogate, above max, stray, bad lead, broken sequence
		'{CMD_BYTE, 8'hC0, 1'b1, '{ST_PROGRESS, 1'b0, 1'b0, 21'h0, 10'd0, 12'd1}},
		'{CMD_BYTE, 8'h80, 1'b1, '{ST_INVALID, 1'b0, 1'b0, 21'h0, 10'd0, 12'd2}},
		'{CMD_BYTE, 8'hED, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hA0, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h80, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hF4, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h90, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h80, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h80, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h80, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hFF, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'hC2, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h41, 1'b1, '{ST_INVALID, 1'b0, 1'b1, 21'h41, 10'd1, 12'd13}},
		'{CMD_END,  8'h5A, 1'b1, '{ST_INVALID, 1'b1, 1'b0, 21'h0, 10'd1, 12'd13}},
		'{CMD_BYTE, 8'hE2, 1'b0, NO_VERDICT},
		'{CMD_BYTE, 8'h82, 1'b0, NO_VERDICT},
		'{CMD_END,  8'hFF, 1'b1, '{ST_TRUNCATED, 1'b1, 1'b0, 21'h0, 10'd0, 12'd2}}
	};

	task automatic report(string msg);
		if (n_fail < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		n_fail++;
	endtask

	function automatic void clear_text();
		dec_pend  = 2'd0;
		dec_part  = '0;
		dec_cls   = 2'd0;
		txt_chars = '0;
		txt_bytes = '0;
		txt_err   = ST_PROGRESS;
	endfunction

	function automatic void keep_first_error(status_t code);
		if (txt_err == ST_PROGRESS)
			txt_err = code;
	endfunction

	function automatic bit take_char(logic [CP_W-1:0] cp, logic [1:0] cls);
		logic [CP_W-1:0]   lo;
		logic [CHAR_W:0]   nc;
		case (cls)
			2'd1: lo = 21'h80;
			2'd2: lo = 21'h800;
			2'd3: lo = 21'h10000;
			default: lo = 21'h0;
		endcase
		if (cp < lo || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
			keep_first_error(ST_INVALID);
			return 1'b0;
		end
		nc = {1'b0, txt_chars} + 1'b1;
		if (nc > lim_chars)
			keep_first_error(ST_TOO_LONG);
		txt_chars = nc[CHAR_W] ? '1 : nc[CHAR_W-1:0];
		return 1'b1;
	endfunction

	function automatic verdict_t validate_byte(cmd_t c, logic [7:0] b);
		verdict_t        r;
		logic [BYTE_W:0] nb;
		r = NO_VERDICT;
		if (c == CMD_END) begin
			if (txt_err == ST_TOO_LONG || txt_bytes > lim_bytes)
				r.status = ST_TOO_LONG;
			else if (txt_err != ST_PROGRESS)
				r.status = txt_err;
			else if (dec_pend != 2'd0)
				r.status = ST_TRUNCATED;
			else
				r.status = ST_VALID;
			r.final_verdict = 1'b1;
			r.chars_seen    = txt_chars;
			r.bytes_seen    = txt_bytes;
			clear_text();
			return r;
		end
		nb = {1'b0, txt_bytes} + 1'b1;
		if (nb > lim_bytes)
			txt_err = ST_TOO_LONG;
		txt_bytes = nb[BYTE_W] ? '1 : nb[BYTE_W-1:0];
		if (b[7:6] == 2'b10 && dec_pend != 2'd0) begin
			dec_part = {dec_part[CP_W-7:0], b[5:0]};
			dec_pend = dec_pend - 2'd1;
			if (dec_pend == 2'd0) begin
				if (take_char(dec_part, dec_cls)) begin
					r.char_complete = 1'b1;
					r.code_point    = dec_part;
				end
				dec_part = '0;
				dec_cls  = 2'd0;
			end
		end else begin
			if (dec_pend != 2'd0) begin
				keep_first_error(ST_INVALID);
				dec_pend = 2'd0;
				dec_part = '0;
				dec_cls  = 2'd0;
			end
			if (!b[7]) begin
				if (take_char({14'd0, b[6:0]}, 2'd0)) begin
					r.char_complete = 1'b1;
					r.code_point    = {14'd0, b[6:0]};
				end
			end else if (b[7:5] == 3'b110) begin
				dec_part = {16'd0, b[4:0]};
				dec_pend = 2'd1;
				dec_cls  = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				dec_part = {17'd0, b[3:0]};
				dec_pend = 2'd2;
				dec_cls  = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				dec_part = {18'd0, b[2:0]};
				dec_pend = 2'd3;
				dec_cls  = 2'd3;
			end else begin
				keep_first_error(ST_INVALID);
			end
		end
		r.status     = txt_err;
		r.chars_seen = txt_chars;
		r.bytes_seen = txt_bytes;
		return r;
	endfunction

	function automatic void encode_char(logic [CP_W-1:0] cp, int n);
		case (n)
			1: text_bytes.push_back({1'b0, cp[6:0]});
			2: text_bytes.push_back({3'b110, cp[10:6]});
			3: text_bytes.push_back({4'b1110, cp[15:12]});
			default: text_bytes.push_back({5'b11110, cp[20:18]});
		endcase
		for (int k = n - 2; k >= 0; k--)
			text_bytes.push_back({2'b10, cp[6*k +: 6]});
	endfunction

	task automatic add_char();
		int unsigned     kind;
		int unsigned     cls;
		int unsigned     n;
		logic [CP_W-1:0] cp;
		kind = $urandom_range(99);
		if (kind < 6) begin
			text_bytes.push_back(8'($urandom_range(255)));
		end else if (kind < 12) begin
			case ($urandom_range(2))
				0: begin
					n = $urandom_range(4, 2);
					case (n)
						2: cp = 21'($urandom_range(21'h7F, 0));
						3: cp = 21'($urandom_range(21'h7FF, 0));
						default: cp = 21'($urandom_range(21'hFFFF, 0));
					endcase
					encode_char(cp, n);
				end
				1: encode_char(21'($urandom_range(SURR_HI, SURR_LO)), 3);
				default: encode_char(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
			endcase
		end else begin
			cls = $urandom_range(4, 1);
			case (cls)
				1: cp = 21'($urandom_range(21'h7F, 0));
				2: cp = 21'($urandom_range(21'h7FF, 21'h80));
				3: cp = 21'($urandom_range(21'hFFFF, 21'h800));
				default: cp = 21'($urandom_range(CP_MAX, 21'h10000));
			endcase
			encode_char(cp, cls);
			// truncated sequence
			if (kind < 18 && cls > 1)
				repeat ($urandom_range(cls - 1, 1))
					void'(text_bytes.pop_back());
		end
	endtask

	task automatic push(cmd_t c, logic [7:0] b, bit typed, verdict_t want);
		verdict_t p;
		while ($urandom_range(99) < src_idle) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.command   <= c;
		text_ch.text_byte <= b;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		p = validate_byte(c, b);
		pending_verdicts.push_back(typed ? want : p);
		n_sent++;
	endtask

	task automatic run_texts(int quota);
		int start;
		int nchars;
		start = n_sent;
		while (n_sent - start < quota) begin
			nchars = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(8);
			text_bytes.delete();
			repeat (nchars)
				add_char();
			foreach (text_bytes[i])
				push(CMD_BYTE, text_bytes[i], 1'b0, NO_VERDICT);
			push(CMD_END, 8'($urandom_range(255)), 1'b0, NO_VERDICT);
		end
	endtask

	task automatic drain();
		text_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limits(logic [CHAR_W-1:0] cl, logic [BYTE_W-1:0] bl);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CHAR_LIMIT;
		cfg_data  <= CFG_DATA_W'(cl);
		@(posedge clk);
		cfg_index <= CFG_BYTE_LIMIT;
		cfg_data  <= bl;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_chars = cl;
		lim_bytes = bl;
	endtask

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= rcv_idle);

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report("result transaction with nothing expected");
			end else begin
				e = pending_verdicts.pop_front();
				if (result_ch.status !== e.status)
					report($sformatf("status %0d, want %0d", result_ch.status, e.status));
				if (result_ch.final_verdict !== e.final_verdict)
					report($sformatf("final_verdict %0b, want %0b",
						result_ch.final_verdict, e.final_verdict));
				if (result_ch.char_complete !== e.char_complete)
					report($sformatf("char_complete %0b, want %0b",
						result_ch.char_complete, e.char_complete));
				if (result_ch.code_point !== e.code_point)
					report($sformatf("code_point %h, want %h", result_ch.code_point, e.code_point));
				if (result_ch.chars_seen !== e.chars_seen)
					report($sformatf("chars_seen %0d, want %0d",
						result_ch.chars_seen, e.chars_seen));
				if (result_ch.bytes_seen !== e.bytes_seen)
					report($sformatf("bytes_seen %0d, want %0d",
						result_ch.bytes_seen, e.bytes_seen));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("utf8_validate_count_top regression: fail");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_CHAR_LIMIT;
		cfg_data          = '0;
		text_ch.valid     = 1'b0;
		text_ch.command   = CMD_BYTE;
		text_ch.text_byte = 8'h00;
		lim_chars         = CHAR_LIMIT_RST;
		lim_bytes         = BYTE_LIMIT_RST;
		clear_text();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 11;
		rcv_idle = 61;
		foreach (script[i])
			push(script[i].cmd, script[i].data, script[i].typed, script[i].want);
		run_texts(200);
		drain();
		set_limits(10'd0, 12'd0);
		run_texts(120);

		src_idle = 61;
		rcv_idle = 11;
		drain();
		set_limits(10'd1023, 12'd4095);
		run_texts(250);
		drain();
		set_limits(10'd7, 12'd24);
		run_texts(250);

		src_idle = 0;
		rcv_idle = 0;
		drain();
		set_limits(10'($urandom_range(40)), 12'($urandom_range(120)));
		run_texts(150);
		drain();
		set_limits(10'd1023, 12'd60);
		run_texts(150);

		drain();
		repeat (8)
			@(posedge clk);
		if (pending_verdicts.size() != 0)
			report($sformatf("%0d results never arrived", pending_verdicts.size()));
		if (n_fail == 0)
			$display("utf8_validate_count_top regression: pass");
		else
			$display("utf8_validate_count_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
